### rtl/core/cfle_pkg.sv
// ----------------------------------------------------------------------------
// cfle_pkg - shared types for the crc-8 framed link engine
// Command, result kind, reply status and receive phase codes, the result
// record and the crc-8 byte step.
// ----------------------------------------------------------------------------
package cfle_pkg;

  // input command codes
  typedef enum logic [1:0] {
    CMD_RX_BYTE = 2'd0,
    CMD_TX_BYTE = 2'd1,
    CMD_START   = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TX_BYTE = 2'd0,
    KIND_TX_CRC  = 2'd1,
    KIND_RX_BYTE = 2'd2,
    KIND_STATUS  = 2'd3
  } kind_e;

  // reply status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_TIMEOUT = 2'd2
  } status_e;

  // receive phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ADDR = 3'd1,
    PH_FUNC = 3'd2,
    PH_LEN  = 3'd3,
    PH_PAY  = 3'd4,
    PH_CRC  = 3'd5
  } rx_phase_e;

  localparam int unsigned TimeoutW = 14;
  localparam logic [TimeoutW-1:0] TimeoutMin   = 14'd51;
  localparam logic [TimeoutW-1:0] TimeoutMax   = 14'd9999;
  localparam logic [TimeoutW-1:0] TimeoutReset = 14'd300;
  localparam logic [TimeoutW-1:0] TickSat      = 14'h3fff;

  // reflected polynomial of the maxim crc-8
  localparam logic [7:0] CrcPoly = 8'h8c;

  // one result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    status_e    status;
    logic [7:0] address;
    logic [7:0] func;
    logic [7:0] length;
    logic       last;
  } result_t;

  // results produced by one accepted item
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // one byte through the crc-8, lsb first
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/cfle_core.sv
// ----------------------------------------------------------------------------
// cfle_core - frame state and result generation
// Holds the timeout register, the transmit crc, the receive phase machine
// and the tick counter; turns each accepted item into zero to two results.
// ----------------------------------------------------------------------------
module cfle_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [1:0]                       command_i,
  input  logic [7:0]                       data_byte_i,
  input  logic                             tx_final_i,
  input  logic                             cfg_write_i,
  input  logic [cfle_pkg::TimeoutW-1:0]    cfg_data_i,
  output cfle_pkg::push_t                  push_o
);
  import cfle_pkg::*;

  rx_phase_e           phase_q, phase_d;
  logic [7:0]          addr_q, addr_d;
  logic [7:0]          func_q, func_d;
  logic [7:0]          len_q, len_d;
  logic [7:0]          remain_q, remain_d;
  logic [7:0]          rx_crc_q, rx_crc_d;
  logic [7:0]          tx_crc_q, tx_crc_d;
  logic [TimeoutW-1:0] tick_q, tick_d;
  logic [TimeoutW-1:0] timeout_q;
  logic [7:0]          tx_crc_next;
  logic [7:0]          rx_crc_next;
  logic [TimeoutW-1:0] tick_inc;
  logic [7:0]          remain_dec;

  assign tx_crc_next = crc8_step(tx_crc_q, data_byte_i);
  assign rx_crc_next = crc8_step(rx_crc_q, data_byte_i);
  assign tick_inc    = (tick_q == TickSat) ? tick_q : tick_q + 1'b1;
  assign remain_dec  = remain_q - 8'd1;

  // timeout register, out of range writes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_write_i && cfg_data_i >= TimeoutMin && cfg_data_i <= TimeoutMax) begin
      timeout_q <= cfg_data_i;
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      addr_q   <= '0;
      func_q   <= '0;
      len_q    <= '0;
      remain_q <= '0;
      rx_crc_q <= '0;
      tx_crc_q <= '0;
      tick_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      func_q   <= func_d;
      len_q    <= len_d;
      remain_q <= remain_d;
      rx_crc_q <= rx_crc_d;
      tx_crc_q <= tx_crc_d;
      tick_q   <= tick_d;
    end
  end

  // next state and results
  always_comb begin
    phase_d  = phase_q;
    addr_d   = addr_q;
    func_d   = func_q;
    len_d    = len_q;
    remain_d = remain_q;
    rx_crc_d = rx_crc_q;
    tx_crc_d = tx_crc_q;
    tick_d   = tick_q;
    push_o   = '0;
    if (accept_i) begin
      unique case (cmd_e'(command_i))
        CMD_TX_BYTE: begin
          push_o.first.kind     = KIND_TX_BYTE;
          push_o.first.out_byte = data_byte_i;
          if (tx_final_i) begin
            push_o.count           = 2'd2;
            push_o.second.kind     = KIND_TX_CRC;
            push_o.second.out_byte = tx_crc_next;
            push_o.second.last     = 1'b1;
            tx_crc_d               = '0;
          end else begin
            push_o.count      = 2'd1;
            push_o.first.last = 1'b1;
            tx_crc_d          = tx_crc_next;
          end
        end
        CMD_START: begin
          phase_d  = PH_ADDR;
          addr_d   = '0;
          func_d   = '0;
          len_d    = '0;
          remain_d = '0;
          rx_crc_d = '0;
          tick_d   = '0;
        end
        CMD_TICK: begin
          if (phase_q != PH_IDLE) begin
            tick_d = tick_inc;
            if (tick_inc >= timeout_q) begin
              phase_d              = PH_IDLE;
              push_o.count         = 2'd1;
              push_o.first.kind    = KIND_STATUS;
              push_o.first.status  = STATUS_TIMEOUT;
              push_o.first.address = addr_q;
              push_o.first.func    = func_q;
              push_o.first.length  = len_q;
              push_o.first.last    = 1'b1;
            end
          end
        end
        CMD_RX_BYTE: begin
          unique case (phase_q)
            PH_ADDR: begin
              addr_d   = data_byte_i;
              rx_crc_d = rx_crc_next;
              phase_d  = PH_FUNC;
            end
            PH_FUNC: begin
              func_d   = data_byte_i;
              rx_crc_d = rx_crc_next;
              phase_d  = PH_LEN;
            end
            PH_LEN: begin
              len_d    = data_byte_i;
              remain_d = data_byte_i;
              rx_crc_d = rx_crc_next;
              phase_d  = (data_byte_i == 8'd0) ? PH_CRC : PH_PAY;
            end
            PH_PAY: begin
              rx_crc_d              = rx_crc_next;
              remain_d              = remain_dec;
              if (remain_dec == 8'd0) begin
                phase_d = PH_CRC;
              end
              push_o.count          = 2'd1;
              push_o.first.kind     = KIND_RX_BYTE;
              push_o.first.out_byte = data_byte_i;
              push_o.first.last     = 1'b1;
            end
            PH_CRC: begin
              phase_d              = PH_IDLE;
              push_o.count         = 2'd1;
              push_o.first.kind    = KIND_STATUS;
              push_o.first.status  = (data_byte_i == rx_crc_q) ? STATUS_OK : STATUS_CRC_ERR;
              push_o.first.address = addr_q;
              push_o.first.func    = func_q;
              push_o.first.length  = len_q;
              push_o.first.last    = 1'b1;
            end
            default: begin
              // idle or unused code: byte dropped
              phase_d = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // two results only for a final transmit byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (accept_i && command_i == CMD_TX_BYTE && tx_final_i))
    else $error("two results without a final transmit byte");

  // limit register always holds a legal value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timeout_q >= TimeoutMin && timeout_q <= TimeoutMax))
    else $error("timeout register out of range");

  // a crc byte always closes the exchange with a status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && command_i == CMD_RX_BYTE && phase_q == PH_CRC)
      |=> (phase_q == PH_IDLE))
    else $error("exchange not closed after crc byte");

  // payload phase never entered with nothing left to receive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (remain_q != 8'd0))
    else $error("payload phase with zero bytes remaining");

endmodule

### rtl/core/cfle_outq.sv
// ----------------------------------------------------------------------------
// cfle_outq - result queue
// Small circular buffer that takes up to two results a cycle and hands
// them out one per handshake; input stall comes from its fill level.
// ----------------------------------------------------------------------------
module cfle_outq #(
  parameter int unsigned OutDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfle_pkg::push_t   push_i,
  input  logic              pop_i,
  output logic              room_o,
  output logic              valid_o,
  output cfle_pkg::result_t head_o
);
  import cfle_pkg::*;

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(OutDepth - 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(OutDepth - 2);

  result_t         mem_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wr_ptr_next;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_next = ptr_inc(wr_ptr_q);
  assign room_o      = (count_q <= RoomMax);
  assign valid_o     = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    unique case (push_i.count)
      2'd1:    wr_ptr_d = wr_ptr_next;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_next);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    if (pop_i) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    count_d = count_q + CntW'(push_i.count) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.second;
    end
  end

  // fill level never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(OutDepth))
    else $error("result queue overflow");

  // no pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("result queue underflow");

  // results only pushed while room was reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("push into a full result queue");

endmodule

### rtl/core/crc8_frame_link_engine.sv
// ----------------------------------------------------------------------------
// crc8_frame_link_engine - crc-8 framed serial link engine
// Transmit path passes bytes and appends the maxim crc-8; receive path
// tracks address, function, length and payload and reports a status.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o command_i, data_byte_i, tx_final_i
//  out      output     out_valid_o/out_stall_i kind_o, out_byte_o, reply_*_o, last_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (reply timeout ticks)
//
//  one item per cycle while in_stall_o is low; the crc step and phase update settle
//  in the cycle of acceptance; a final transmit byte yields a byte and a crc result
//  in_stall_o rises when the result queue has fewer than two free entries
//  output stalls hold the queue head; the input stops once under two entries are free
//  reset clears the frame state, the queue, and loads a timeout of 300 ticks
// ----------------------------------------------------------------------------
module crc8_frame_link_engine #(
  parameter int unsigned OutDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        tx_final_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  reply_status_o,
  output logic [7:0]  reply_address_o,
  output logic [7:0]  reply_function_o,
  output logic [7:0]  reply_length_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [13:0] cfg_data_i
);
  import cfle_pkg::*;

  logic    accept;
  logic    room;
  logic    pop;
  push_t   push;
  result_t head;

  assign in_stall_o  = !room;
  assign accept      = in_valid_i && room;
  assign pop         = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // frame engine
  cfle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .tx_final_i  (tx_final_i),
    .cfg_write_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push)
  );

  // result queue
  cfle_outq #(
    .OutDepth (OutDepth)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  // result fields
  assign kind_o           = head.kind;
  assign out_byte_o       = head.out_byte;
  assign reply_status_o   = head.status;
  assign reply_address_o  = head.address;
  assign reply_function_o = head.func;
  assign reply_length_o   = head.length;
  assign last_o           = head.last;

endmodule
